// ===== hdl/dbf_pkg.sv =====
// Shared constants, types and helpers of the deblocking edge filter.
package dbf_pkg;

    // Sample depth that the thresholds and clip limits are scaled to
    localparam int PIXEL_BITS  = 8;
    localparam int DEPTH_SHIFT = PIXEL_BITS - 8;

    // Field widths
    localparam int PIX_W = 8;
    localparam int CB_W  = 6;

    // Derived internal widths
    localparam int THR_W = PIX_W + DEPTH_SHIFT;         // scaled alpha and beta
    localparam int TC_W  = CB_W + DEPTH_SHIFT + 1;      // clip limit plus side growth
    localparam int SUM_W = PIX_W + 4;                   // raw delta numerator
    localparam int D_W   = PIX_W + 1;                   // delta after the divide by 8
    localparam int CMP_W = (TC_W > D_W) ? TC_W : D_W;   // clamp compare width
    localparam int S_W   = PIX_W + 3;                   // smoothing tap sums

    // Saturation limit of the normal-mode p0/q0 results
    localparam int PIX_MAX_RAW = (1 << PIXEL_BITS) - 1;
    localparam int PIX_LIM     = (PIX_MAX_RAW < 255) ? PIX_MAX_RAW : 255;

    typedef enum logic [1:0] {
        OP_LUMA_NORMAL   = 2'd0,
        OP_LUMA_STRONG   = 2'd1,
        OP_CHROMA_NORMAL = 2'd2,
        OP_CHROMA_STRONG = 2'd3
    } t_op;

    typedef logic        [PIX_W-1:0] t_pix;
    typedef logic        [THR_W-1:0] t_thr;
    typedef logic        [THR_W:0]   t_near;
    typedef logic signed [TC_W-1:0]  t_tc;
    typedef logic signed [CMP_W-1:0] t_cmp;
    typedef logic signed [SUM_W-1:0] t_sum;
    typedef logic signed [D_W-1:0]   t_d;
    typedef logic signed [D_W:0]     t_v0;
    typedef logic        [S_W-1:0]   t_acc;

    // One request as it enters the pipeline
    typedef struct packed {
        t_op                    op;
        t_pix                   p3;
        t_pix                   p2;
        t_pix                   p1;
        t_pix                   p0;
        t_pix                   q0;
        t_pix                   q1;
        t_pix                   q2;
        t_pix                   q3;
        t_pix                   alpha;
        t_pix                   beta;
        logic signed [CB_W-1:0] clip_base;
    } t_line;

    // Outcome of the gradient and limit tests
    typedef struct packed {
        logic edge_ok;
        logic p_side;
        logic q_side;
        logic near;
        logic luma_ok;
        logic chroma_ok;
    } t_flags;

    typedef struct packed {
        t_op    op;
        t_flags flags;
        t_pix   p2;
        t_pix   p1;
        t_pix   p0;
        t_pix   q0;
        t_pix   q1;
        t_pix   q2;
        t_tc    tco;
        t_tc    tc;
        t_pix   avg;
        t_d     d_raw;
        t_pix   sp2;
        t_pix   sp1;
        t_pix   sp0;
        t_pix   sq0;
        t_pix   sq1;
        t_pix   sq2;
        t_pix   wp0;
        t_pix   wq0;
    } t_s1;

    typedef struct packed {
        t_op    op;
        t_flags flags;
        t_pix   p2;
        t_pix   p1;
        t_pix   p0;
        t_pix   q0;
        t_pix   q1;
        t_pix   q2;
        t_pix   np1;
        t_pix   nq1;
        t_d     d;
        t_pix   st_p2;
        t_pix   st_p1;
        t_pix   st_p0;
        t_pix   st_q0;
        t_pix   st_q1;
        t_pix   st_q2;
        t_pix   wp0;
        t_pix   wq0;
    } t_s2;

    typedef struct packed {
        t_pix p2;
        t_pix p1;
        t_pix p0;
        t_pix q0;
        t_pix q1;
        t_pix q2;
        logic filtered;
    } t_res;

    function automatic t_pix absd(input t_pix a, input t_pix b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

endpackage

// ===== hdl/dbf_if.sv =====
// Request and result channel interfaces of the deblocking edge filter.
interface dbf_line_if;
    logic                            valid;
    logic                            ready;
    logic [1:0]                      op;
    dbf_pkg::t_pix                   p3_in;
    dbf_pkg::t_pix                   p2_in;
    dbf_pkg::t_pix                   p1_in;
    dbf_pkg::t_pix                   p0_in;
    dbf_pkg::t_pix                   q0_in;
    dbf_pkg::t_pix                   q1_in;
    dbf_pkg::t_pix                   q2_in;
    dbf_pkg::t_pix                   q3_in;
    dbf_pkg::t_pix                   edge_alpha;
    dbf_pkg::t_pix                   edge_beta;
    logic signed [dbf_pkg::CB_W-1:0] clip_base;

    modport source (
        output valid, op, p3_in, p2_in, p1_in, p0_in, q0_in, q1_in, q2_in, q3_in,
               edge_alpha, edge_beta, clip_base,
        input  ready
    );
    modport sink (
        input  valid, op, p3_in, p2_in, p1_in, p0_in, q0_in, q1_in, q2_in, q3_in,
               edge_alpha, edge_beta, clip_base,
        output ready
    );
endinterface

interface dbf_res_if;
    logic          valid;
    logic          ready;
    dbf_pkg::t_pix p2_out;
    dbf_pkg::t_pix p1_out;
    dbf_pkg::t_pix p0_out;
    dbf_pkg::t_pix q0_out;
    dbf_pkg::t_pix q1_out;
    dbf_pkg::t_pix q2_out;
    logic          filtered;

    modport source (
        output valid, p2_out, p1_out, p0_out, q0_out, q1_out, q2_out, filtered,
        input  ready
    );
    modport sink (
        input  valid, p2_out, p1_out, p0_out, q0_out, q1_out, q2_out, filtered,
        output ready
    );
endinterface

// ===== hdl/dbf_grad.sv =====
// Stage 1: gradient tests, clip limits, raw delta and smoothing taps.
module dbf_grad (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  dbf_pkg::t_line i_data,
    output logic           o_valid,
    output dbf_pkg::t_s1   o_data
);
    dbf_pkg::t_thr w_alpha;
    dbf_pkg::t_thr w_beta;
    dbf_pkg::t_tc  w_tco;
    dbf_pkg::t_tc  w_tc_luma;
    dbf_pkg::t_tc  w_tc_chroma;
    dbf_pkg::t_sum w_dsum;
    logic          w_edge;
    logic          w_p_side;
    logic          w_q_side;
    logic          w_near;
    dbf_pkg::t_s1  n_data;
    dbf_pkg::t_s1  r_data;
    logic          r_valid;

    // Scale the thresholds to the sample depth
    assign w_alpha = dbf_pkg::t_thr'(i_data.alpha) << dbf_pkg::DEPTH_SHIFT;
    assign w_beta  = dbf_pkg::t_thr'(i_data.beta) << dbf_pkg::DEPTH_SHIFT;

    // Check the edge step and the inner gradients
    assign w_edge =
        (dbf_pkg::t_thr'(dbf_pkg::absd(i_data.p0, i_data.q0)) < w_alpha) &&
        (dbf_pkg::t_thr'(dbf_pkg::absd(i_data.p1, i_data.p0)) < w_beta) &&
        (dbf_pkg::t_thr'(dbf_pkg::absd(i_data.q1, i_data.q0)) < w_beta);
    assign w_p_side = dbf_pkg::t_thr'(dbf_pkg::absd(i_data.p2, i_data.p0)) < w_beta;
    assign w_q_side = dbf_pkg::t_thr'(dbf_pkg::absd(i_data.q2, i_data.q0)) < w_beta;
    assign w_near   = dbf_pkg::t_near'(dbf_pkg::absd(i_data.p0, i_data.q0)) <
                      (dbf_pkg::t_near'(w_alpha >> 2) + dbf_pkg::t_near'(2));

    // Build the clip limits; luma grows by one per smooth side
    assign w_tco       = dbf_pkg::t_tc'(i_data.clip_base) <<< dbf_pkg::DEPTH_SHIFT;
    assign w_tc_luma   = w_tco + dbf_pkg::t_tc'(w_p_side) + dbf_pkg::t_tc'(w_q_side);
    assign w_tc_chroma = ((dbf_pkg::t_tc'(i_data.clip_base) - dbf_pkg::t_tc'(1))
                          <<< dbf_pkg::DEPTH_SHIFT) + dbf_pkg::t_tc'(1);

    // Form the raw delta numerator
    assign w_dsum = ((dbf_pkg::t_sum'(i_data.q0) - dbf_pkg::t_sum'(i_data.p0)) <<< 2) +
                    dbf_pkg::t_sum'(i_data.p1) - dbf_pkg::t_sum'(i_data.q1) +
                    dbf_pkg::t_sum'(4);

    // Collect everything the next stage needs
    always_comb begin
        n_data.op              = i_data.op;
        n_data.flags.edge_ok   = w_edge;
        n_data.flags.p_side    = w_p_side;
        n_data.flags.q_side    = w_q_side;
        n_data.flags.near      = w_near;
        n_data.flags.luma_ok   = !i_data.clip_base[dbf_pkg::CB_W-1];
        n_data.flags.chroma_ok = !i_data.clip_base[dbf_pkg::CB_W-1] &&
                                 (i_data.clip_base != '0);
        n_data.p2    = i_data.p2;
        n_data.p1    = i_data.p1;
        n_data.p0    = i_data.p0;
        n_data.q0    = i_data.q0;
        n_data.q1    = i_data.q1;
        n_data.q2    = i_data.q2;
        n_data.tco   = w_tco;
        n_data.tc    = (i_data.op == dbf_pkg::OP_CHROMA_NORMAL) ? w_tc_chroma : w_tc_luma;
        n_data.avg   = dbf_pkg::t_pix'((dbf_pkg::t_acc'(i_data.p0) +
                                        dbf_pkg::t_acc'(i_data.q0) +
                                        dbf_pkg::t_acc'(1)) >> 1);
        n_data.d_raw = dbf_pkg::t_d'(w_dsum >>> 3);
        // Strong smoothing taps
        n_data.sp0 = dbf_pkg::t_pix'((dbf_pkg::t_acc'(i_data.p2) +
                                      (dbf_pkg::t_acc'(i_data.p1) << 1) +
                                      (dbf_pkg::t_acc'(i_data.p0) << 1) +
                                      (dbf_pkg::t_acc'(i_data.q0) << 1) +
                                      dbf_pkg::t_acc'(i_data.q1) +
                                      dbf_pkg::t_acc'(4)) >> 3);
        n_data.sp1 = dbf_pkg::t_pix'((dbf_pkg::t_acc'(i_data.p2) +
                                      dbf_pkg::t_acc'(i_data.p1) +
                                      dbf_pkg::t_acc'(i_data.p0) +
                                      dbf_pkg::t_acc'(i_data.q0) +
                                      dbf_pkg::t_acc'(2)) >> 2);
        n_data.sp2 = dbf_pkg::t_pix'(((dbf_pkg::t_acc'(i_data.p3) << 1) +
                                      (dbf_pkg::t_acc'(i_data.p2) << 1) +
                                      dbf_pkg::t_acc'(i_data.p2) +
                                      dbf_pkg::t_acc'(i_data.p1) +
                                      dbf_pkg::t_acc'(i_data.p0) +
                                      dbf_pkg::t_acc'(i_data.q0) +
                                      dbf_pkg::t_acc'(4)) >> 3);
        n_data.sq0 = dbf_pkg::t_pix'((dbf_pkg::t_acc'(i_data.p1) +
                                      (dbf_pkg::t_acc'(i_data.p0) << 1) +
                                      (dbf_pkg::t_acc'(i_data.q0) << 1) +
                                      (dbf_pkg::t_acc'(i_data.q1) << 1) +
                                      dbf_pkg::t_acc'(i_data.q2) +
                                      dbf_pkg::t_acc'(4)) >> 3);
        n_data.sq1 = dbf_pkg::t_pix'((dbf_pkg::t_acc'(i_data.p0) +
                                      dbf_pkg::t_acc'(i_data.q0) +
                                      dbf_pkg::t_acc'(i_data.q1) +
                                      dbf_pkg::t_acc'(i_data.q2) +
                                      dbf_pkg::t_acc'(2)) >> 2);
        n_data.sq2 = dbf_pkg::t_pix'(((dbf_pkg::t_acc'(i_data.q3) << 1) +
                                      (dbf_pkg::t_acc'(i_data.q2) << 1) +
                                      dbf_pkg::t_acc'(i_data.q2) +
                                      dbf_pkg::t_acc'(i_data.q1) +
                                      dbf_pkg::t_acc'(i_data.q0) +
                                      dbf_pkg::t_acc'(i_data.p0) +
                                      dbf_pkg::t_acc'(4)) >> 3);
        // Three-tap taps for the weak intra case
        n_data.wp0 = dbf_pkg::t_pix'(((dbf_pkg::t_acc'(i_data.p1) << 1) +
                                      dbf_pkg::t_acc'(i_data.p0) +
                                      dbf_pkg::t_acc'(i_data.q1) +
                                      dbf_pkg::t_acc'(2)) >> 2);
        n_data.wq0 = dbf_pkg::t_pix'(((dbf_pkg::t_acc'(i_data.q1) << 1) +
                                      dbf_pkg::t_acc'(i_data.q0) +
                                      dbf_pkg::t_acc'(i_data.p1) +
                                      dbf_pkg::t_acc'(2)) >> 2);
    end

    // Advance the valid bit when the stage moves
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    // Load the payload when the stage moves
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== hdl/dbf_clip.sv =====
// Stage 2: clip the p1/q1 corrections and the p0/q0 delta, pick strong taps.
module dbf_clip (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_en,
    input  logic         i_valid,
    input  dbf_pkg::t_s1 i_data,
    output logic         o_valid,
    output dbf_pkg::t_s2 o_data
);
    dbf_pkg::t_pix w_tp;
    dbf_pkg::t_pix w_tq;
    dbf_pkg::t_cmp w_dp;
    dbf_pkg::t_cmp w_dq;
    dbf_pkg::t_cmp w_tco;
    dbf_pkg::t_cmp w_cp;
    dbf_pkg::t_cmp w_cq;
    dbf_pkg::t_cmp w_dr;
    dbf_pkg::t_cmp w_tc;
    dbf_pkg::t_cmp w_dc;
    logic          w_sp;
    logic          w_sq;
    dbf_pkg::t_s2  n_data;
    dbf_pkg::t_s2  r_data;
    logic          r_valid;

    // Target of the p1/q1 correction
    assign w_tp = dbf_pkg::t_pix'((dbf_pkg::t_acc'(i_data.p2) +
                                   dbf_pkg::t_acc'(i_data.avg)) >> 1);
    assign w_tq = dbf_pkg::t_pix'((dbf_pkg::t_acc'(i_data.q2) +
                                   dbf_pkg::t_acc'(i_data.avg)) >> 1);
    assign w_dp = dbf_pkg::t_cmp'(w_tp) - dbf_pkg::t_cmp'(i_data.p1);
    assign w_dq = dbf_pkg::t_cmp'(w_tq) - dbf_pkg::t_cmp'(i_data.q1);

    // Clamp the side corrections to the base limit
    assign w_tco = dbf_pkg::t_cmp'(i_data.tco);
    assign w_cp  = (w_dp < -w_tco) ? -w_tco : ((w_dp > w_tco) ? w_tco : w_dp);
    assign w_cq  = (w_dq < -w_tco) ? -w_tco : ((w_dq > w_tco) ? w_tco : w_dq);

    // Clamp the edge delta to the grown limit
    assign w_dr = dbf_pkg::t_cmp'(i_data.d_raw);
    assign w_tc = dbf_pkg::t_cmp'(i_data.tc);
    assign w_dc = (w_dr < -w_tc) ? -w_tc : ((w_dr > w_tc) ? w_tc : w_dr);

    // Strong filtering of a side needs a small step and a smooth side
    assign w_sp = i_data.flags.near && i_data.flags.p_side;
    assign w_sq = i_data.flags.near && i_data.flags.q_side;

    always_comb begin
        n_data.op    = i_data.op;
        n_data.flags = i_data.flags;
        n_data.p2    = i_data.p2;
        n_data.p1    = i_data.p1;
        n_data.p0    = i_data.p0;
        n_data.q0    = i_data.q0;
        n_data.q1    = i_data.q1;
        n_data.q2    = i_data.q2;
        n_data.np1   = i_data.flags.p_side ?
                       dbf_pkg::t_pix'(dbf_pkg::t_cmp'(i_data.p1) + w_cp) : i_data.p1;
        n_data.nq1   = i_data.flags.q_side ?
                       dbf_pkg::t_pix'(dbf_pkg::t_cmp'(i_data.q1) + w_cq) : i_data.q1;
        n_data.d     = dbf_pkg::t_d'(w_dc);
        n_data.st_p2 = w_sp ? i_data.sp2 : i_data.p2;
        n_data.st_p1 = w_sp ? i_data.sp1 : i_data.p1;
        n_data.st_p0 = w_sp ? i_data.sp0 : i_data.wp0;
        n_data.st_q0 = w_sq ? i_data.sq0 : i_data.wq0;
        n_data.st_q1 = w_sq ? i_data.sq1 : i_data.q1;
        n_data.st_q2 = w_sq ? i_data.sq2 : i_data.q2;
        n_data.wp0   = i_data.wp0;
        n_data.wq0   = i_data.wq0;
    end

    // Advance the valid bit when the stage moves
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    // Load the payload when the stage moves
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== hdl/dbf_apply.sv =====
// Stage 3: apply the delta with saturation and select the result per mode.
module dbf_apply (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  dbf_pkg::t_s2  i_data,
    output logic          o_valid,
    output dbf_pkg::t_res o_data
);
    dbf_pkg::t_v0  w_vp;
    dbf_pkg::t_v0  w_vq;
    dbf_pkg::t_v0  w_lim;
    dbf_pkg::t_pix w_cp0;
    dbf_pkg::t_pix w_cq0;
    dbf_pkg::t_res n_data;
    dbf_pkg::t_res r_data;
    logic          r_valid;

    // Move p0 and q0 by the delta and saturate
    assign w_lim = dbf_pkg::t_v0'(dbf_pkg::PIX_LIM);
    assign w_vp  = dbf_pkg::t_v0'(i_data.p0) + dbf_pkg::t_v0'(i_data.d);
    assign w_vq  = dbf_pkg::t_v0'(i_data.q0) - dbf_pkg::t_v0'(i_data.d);
    assign w_cp0 = (w_vp < dbf_pkg::t_v0'(0)) ? '0 :
                   ((w_vp > w_lim) ? dbf_pkg::t_pix'(w_lim) : dbf_pkg::t_pix'(w_vp));
    assign w_cq0 = (w_vq < dbf_pkg::t_v0'(0)) ? '0 :
                   ((w_vq > w_lim) ? dbf_pkg::t_pix'(w_lim) : dbf_pkg::t_pix'(w_vq));

    // Select the result; untouched pixels pass through
    always_comb begin
        n_data.p2       = i_data.p2;
        n_data.p1       = i_data.p1;
        n_data.p0       = i_data.p0;
        n_data.q0       = i_data.q0;
        n_data.q1       = i_data.q1;
        n_data.q2       = i_data.q2;
        n_data.filtered = 1'b0;
        case (i_data.op)
            dbf_pkg::OP_LUMA_NORMAL: begin
                if (i_data.flags.luma_ok && i_data.flags.edge_ok) begin
                    n_data.p1       = i_data.np1;
                    n_data.p0       = w_cp0;
                    n_data.q0       = w_cq0;
                    n_data.q1       = i_data.nq1;
                    n_data.filtered = 1'b1;
                end
            end
            dbf_pkg::OP_LUMA_STRONG: begin
                if (i_data.flags.edge_ok) begin
                    n_data.p2       = i_data.st_p2;
                    n_data.p1       = i_data.st_p1;
                    n_data.p0       = i_data.st_p0;
                    n_data.q0       = i_data.st_q0;
                    n_data.q1       = i_data.st_q1;
                    n_data.q2       = i_data.st_q2;
                    n_data.filtered = 1'b1;
                end
            end
            dbf_pkg::OP_CHROMA_NORMAL: begin
                if (i_data.flags.chroma_ok && i_data.flags.edge_ok) begin
                    n_data.p0       = w_cp0;
                    n_data.q0       = w_cq0;
                    n_data.filtered = 1'b1;
                end
            end
            dbf_pkg::OP_CHROMA_STRONG: begin
                if (i_data.flags.edge_ok) begin
                    n_data.p0       = i_data.wp0;
                    n_data.q0       = i_data.wq0;
                    n_data.filtered = 1'b1;
                end
            end
            default: begin
                n_data.filtered = 1'b0;
            end
        endcase
    end

    // Advance the valid bit when the output slot moves
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    // Load the result when the output slot moves
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== hdl/deblocking_edge_filter.sv =====
// Top level of the deblocking edge filter: three-stage pipeline and its flow control.
//
// Usage:
//   i_line carries one request per line of eight pixels across a block edge
//   (p3..q3), with alpha, beta, the clip limit and the filter mode. o_line
//   returns p2..q2, filtered or passed through, and the filtered flag.
//   Both channels move a request at a clock edge where valid and ready are high.
// Pipeline: a request passes the gradient tests, the clipping, and the
//   saturation and select, one register stage each, in that order.
// Throughput: one request per cycle while o_line.ready is high; every stage
//   holds one request and nothing in the datapath iterates.
// Stall: the last stage is the output register. Each stage advances when it
//   is empty or the stage after it advances, so bubbles close up and a
//   request is taken while a finished result still waits; with all three
//   stages full and o_line.ready low, i_line.ready drops.
// Reset: i_rst_n is synchronous and active low; it empties all stages, and
//   i_line.ready is high in the first cycle after reset.
module deblocking_edge_filter (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dbf_line_if.sink   i_line,
    dbf_res_if.source  o_line
);
    dbf_pkg::t_line w_line;
    dbf_pkg::t_s1   w_s1;
    dbf_pkg::t_s2   w_s2;
    dbf_pkg::t_res  w_res;
    logic           w_v1;
    logic           w_v2;
    logic           w_v3;
    logic           w_en1;
    logic           w_en2;
    logic           w_en3;
    logic           w_in_acc;

    // Move a stage when it is empty or the one after it moves
    assign w_en3    = !w_v3 || o_line.ready;
    assign w_en2    = !w_v2 || w_en3;
    assign w_en1    = !w_v1 || w_en2;
    assign w_in_acc = i_line.valid && w_en1;

    assign i_line.ready = w_en1;

    // Gather the request fields
    always_comb begin
        w_line.op        = dbf_pkg::t_op'(i_line.op);
        w_line.p3        = i_line.p3_in;
        w_line.p2        = i_line.p2_in;
        w_line.p1        = i_line.p1_in;
        w_line.p0        = i_line.p0_in;
        w_line.q0        = i_line.q0_in;
        w_line.q1        = i_line.q1_in;
        w_line.q2        = i_line.q2_in;
        w_line.q3        = i_line.q3_in;
        w_line.alpha     = i_line.edge_alpha;
        w_line.beta      = i_line.edge_beta;
        w_line.clip_base = i_line.clip_base;
    end

    dbf_grad u_grad (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en1),
        .i_valid (i_line.valid),
        .i_data  (w_line),
        .o_valid (w_v1),
        .o_data  (w_s1)
    );

    dbf_clip u_clip (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en2),
        .i_valid (w_v1),
        .i_data  (w_s1),
        .o_valid (w_v2),
        .o_data  (w_s2)
    );

    dbf_apply u_apply (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en3),
        .i_valid (w_v2),
        .i_data  (w_s2),
        .o_valid (w_v3),
        .o_data  (w_res)
    );

    // Drive the result channel from the output register
    assign o_line.valid    = w_v3;
    assign o_line.p2_out   = w_res.p2;
    assign o_line.p1_out   = w_res.p1;
    assign o_line.p0_out   = w_res.p0;
    assign o_line.q0_out   = w_res.q0;
    assign o_line.q1_out   = w_res.q1;
    assign o_line.q2_out   = w_res.q2;
    assign o_line.filtered = w_res.filtered;

    // Back pressure only when every stage is full and the output is stalled
    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_line.ready |-> (w_v1 && w_v2 && w_v3 && !o_line.ready))
        else $error("input stalled while the pipeline has room");

    // A taken request lands in the first stage
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> w_v1)
        else $error("accepted request lost at stage 1");

    // A held middle stage keeps its request
    a_stage2_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_v2 && !w_en2) |=> w_v2)
        else $error("stalled stage 2 dropped its request");

    // A request behind a drained output moves into the output slot
    a_output_refill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_v2 && w_en3) |=> o_line.valid)
        else $error("stage 2 request did not reach the output");

endmodule

// ===== verif/tb_deblocking_edge_filter.sv =====
// Self-checking testbench of the deblocking edge filter: directed lines, then random lines.
module tb_deblocking_edge_filter;

    localparam int TIMEOUT_UNITS = 2_000_000;
    localparam int DRAIN_CYCLES  = 12;
    localparam int RANDOM_LINES  = 1100;
    localparam int CHUNK_LINES   = 100;

    logic          clk;
    logic          rst_n;
    bit            stall_en;
    int            mismatch_count;
    dbf_pkg::t_res exp_lines[$];
    dbf_pkg::t_res want_res;

    dbf_line_if line_if ();
    dbf_res_if  res_if ();

    deblocking_edge_filter u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_line  (line_if),
        .o_line  (res_if)
    );

    // Generate the clock
    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // End the run if it hangs
    initial begin
        #TIMEOUT_UNITS;
        $display("Some tests failed");
        $finish;
    end

    function automatic int pix_diff(input int a, input int b);
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic int clip3(input int v, input int lo, input int hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    // Compute the filtered line that the block must return for one request
    function automatic dbf_pkg::t_res filter_line(input dbf_pkg::t_line ln);
        int  scale, alpha, beta, cb, tco, tc, avg, d;
        int  p3, p2, p1, p0, q0, q1, q2, q3;
        int  np2, np1, np0, nq0, nq1, nq2;
        bit  pass, hit;
        dbf_pkg::t_res r;
        p3 = int'(ln.p3); p2 = int'(ln.p2); p1 = int'(ln.p1); p0 = int'(ln.p0);
        q0 = int'(ln.q0); q1 = int'(ln.q1); q2 = int'(ln.q2); q3 = int'(ln.q3);
        scale = 1 << dbf_pkg::DEPTH_SHIFT;
        alpha = int'(ln.alpha) * scale;
        beta  = int'(ln.beta) * scale;
        cb    = int'(ln.clip_base);
        if (cb >= 32) cb -= 64;
        np2 = p2; np1 = p1; np0 = p0; nq0 = q0; nq1 = q1; nq2 = q2;
        hit = 1'b0;
        pass = pix_diff(p0, q0) < alpha && pix_diff(p1, p0) < beta &&
               pix_diff(q1, q0) < beta;
        case (ln.op)
            dbf_pkg::OP_LUMA_NORMAL: begin
                tco = cb * scale;
                if (tco >= 0 && pass) begin
                    tc  = tco;
                    avg = (p0 + q0 + 1) >> 1;
                    if (pix_diff(p2, p0) < beta) begin
                        np1 = p1 + clip3(((p2 + avg) >> 1) - p1, -tco, tco);
                        tc++;
                    end
                    if (pix_diff(q2, q0) < beta) begin
                        nq1 = q1 + clip3(((q2 + avg) >> 1) - q1, -tco, tco);
                        tc++;
                    end
                    d   = clip3(((q0 - p0) * 4 + (p1 - q1) + 4) >>> 3, -tc, tc);
                    np0 = clip3(p0 + d, 0, dbf_pkg::PIX_LIM);
                    nq0 = clip3(q0 - d, 0, dbf_pkg::PIX_LIM);
                    hit = 1'b1;
                end
            end
            dbf_pkg::OP_LUMA_STRONG: begin
                if (pass) begin
                    if (pix_diff(p0, q0) < ((alpha >> 2) + 2)) begin
                        if (pix_diff(p2, p0) < beta) begin
                            np0 = (p2 + 2 * p1 + 2 * p0 + 2 * q0 + q1 + 4) >> 3;
                            np1 = (p2 + p1 + p0 + q0 + 2) >> 2;
                            np2 = (2 * p3 + 3 * p2 + p1 + p0 + q0 + 4) >> 3;
                        end else begin
                            np0 = (2 * p1 + p0 + q1 + 2) >> 2;
                        end
                        if (pix_diff(q2, q0) < beta) begin
                            nq0 = (p1 + 2 * p0 + 2 * q0 + 2 * q1 + q2 + 4) >> 3;
                            nq1 = (p0 + q0 + q1 + q2 + 2) >> 2;
                            nq2 = (2 * q3 + 3 * q2 + q1 + q0 + p0 + 4) >> 3;
                        end else begin
                            nq0 = (2 * q1 + q0 + p1 + 2) >> 2;
                        end
                    end else begin
                        np0 = (2 * p1 + p0 + q1 + 2) >> 2;
                        nq0 = (2 * q1 + q0 + p1 + 2) >> 2;
                    end
                    hit = 1'b1;
                end
            end
            dbf_pkg::OP_CHROMA_NORMAL: begin
                tc = (cb - 1) * scale + 1;
                if (tc > 0 && pass) begin
                    d   = clip3(((q0 - p0) * 4 + (p1 - q1) + 4) >>> 3, -tc, tc);
                    np0 = clip3(p0 + d, 0, dbf_pkg::PIX_LIM);
                    nq0 = clip3(q0 - d, 0, dbf_pkg::PIX_LIM);
                    hit = 1'b1;
                end
            end
            default: begin
                if (pass) begin
                    np0 = (2 * p1 + p0 + q1 + 2) >> 2;
                    nq0 = (2 * q1 + q0 + p1 + 2) >> 2;
                    hit = 1'b1;
                end
            end
        endcase
        r.p2 = np2[dbf_pkg::PIX_W-1:0];
        r.p1 = np1[dbf_pkg::PIX_W-1:0];
        r.p0 = np0[dbf_pkg::PIX_W-1:0];
        r.q0 = nq0[dbf_pkg::PIX_W-1:0];
        r.q1 = nq1[dbf_pkg::PIX_W-1:0];
        r.q2 = nq2[dbf_pkg::PIX_W-1:0];
        r.filtered = hit;
        return r;
    endfunction

    function automatic dbf_pkg::t_line make_line(input dbf_pkg::t_op op, input int p3,
                                                 input int p2, input int p1, input int p0,
                                                 input int q0, input int q1, input int q2,
                                                 input int q3, input int alpha,
                                                 input int beta, input int cb);
        dbf_pkg::t_line ln;
        ln.op = op;
        ln.p3 = p3[dbf_pkg::PIX_W-1:0];
        ln.p2 = p2[dbf_pkg::PIX_W-1:0];
        ln.p1 = p1[dbf_pkg::PIX_W-1:0];
        ln.p0 = p0[dbf_pkg::PIX_W-1:0];
        ln.q0 = q0[dbf_pkg::PIX_W-1:0];
        ln.q1 = q1[dbf_pkg::PIX_W-1:0];
        ln.q2 = q2[dbf_pkg::PIX_W-1:0];
        ln.q3 = q3[dbf_pkg::PIX_W-1:0];
        ln.alpha = alpha[dbf_pkg::PIX_W-1:0];
        ln.beta = beta[dbf_pkg::PIX_W-1:0];
        ln.clip_base = cb[dbf_pkg::CB_W-1:0];
        return ln;
    endfunction

    function automatic int near_pix(input int v, input int spread);
        int r;
        r = $urandom_range(0, 2 * spread);
        return clip3(v + r - spread, 0, 255);
    endfunction

    // Build a random request: mostly smooth lines near the thresholds, some noise
    function automatic dbf_pkg::t_line random_line();
        dbf_pkg::t_line ln;
        int    spread, p3, p2, p1, p0, q0, q1, q2, q3, dpq, dmax, alpha, beta;
        ln = make_line(dbf_pkg::t_op'($urandom_range(0, 3)), $urandom_range(0, 255),
                       $urandom_range(0, 255), $urandom_range(0, 255),
                       $urandom_range(0, 255), $urandom_range(0, 255),
                       $urandom_range(0, 255), $urandom_range(0, 255),
                       $urandom_range(0, 255), $urandom_range(0, 255),
                       $urandom_range(0, 255), int'($urandom_range(0, 27)) - 1);
        if ($urandom_range(0, 99) < 80) begin
            spread = 1 << (2 * $urandom_range(0, 3));
            p0 = $urandom_range(0, 255);
            q0 = near_pix(p0, 2 * spread);
            p1 = near_pix(p0, spread);
            p2 = near_pix(p1, spread);
            p3 = near_pix(p2, spread);
            q1 = near_pix(q0, spread);
            q2 = near_pix(q1, spread);
            q3 = near_pix(q2, spread);
            dpq  = pix_diff(p0, q0);
            dmax = (pix_diff(p1, p0) > pix_diff(q1, q0)) ? pix_diff(p1, p0)
                                                           : pix_diff(q1, q0);
            // Land on the threshold now and then so the strict compare is hit
            alpha = ($urandom_range(0, 9) == 0) ? dpq : dpq + 1 + $urandom_range(0, 60);
            beta  = ($urandom_range(0, 9) == 0) ? dmax : dmax + 1 + $urandom_range(0, 24);
            ln = make_line(ln.op, p3, p2, p1, p0, q0, q1, q2, q3,
                           clip3(alpha, 0, 255), clip3(beta, 0, 255),
                           int'(ln.clip_base));
        end
        return ln;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!stall_en || r < 70) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Send one request and record its expected result once it is taken
    task automatic send_line(input dbf_pkg::t_line ln);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            line_if.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        line_if.op         = ln.op;
        line_if.p3_in      = ln.p3;
        line_if.p2_in      = ln.p2;
        line_if.p1_in      = ln.p1;
        line_if.p0_in      = ln.p0;
        line_if.q0_in      = ln.q0;
        line_if.q1_in      = ln.q1;
        line_if.q2_in      = ln.q2;
        line_if.q3_in      = ln.q3;
        line_if.edge_alpha = ln.alpha;
        line_if.edge_beta  = ln.beta;
        line_if.clip_base  = ln.clip_base;
        line_if.valid      = 1'b1;
        do @(posedge clk); while (line_if.ready !== 1'b1);
        exp_lines.push_back(filter_line(ln));
        @(negedge clk);
    endtask

    // Hold off the sender until every expected result is back
    task automatic wait_results();
        line_if.valid = 1'b0;
        while (exp_lines.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic test_directed();
        dbf_pkg::t_line lines[$];
        stall_en = 1'b1;
        lines.push_back(make_line(dbf_pkg::OP_LUMA_NORMAL, 0, 0, 0, 0, 0, 0, 0, 0,
                                  255, 255, 0));
        lines.push_back(make_line(dbf_pkg::OP_LUMA_NORMAL, 255, 255, 255, 255, 255, 255,
                                  255, 255, 255, 255, 26));
        // Zero alpha or zero beta never filters
        lines.push_back(make_line(dbf_pkg::OP_LUMA_NORMAL, 10, 11, 12, 13, 14, 15, 16, 17,
                                  0, 40, 4));
        lines.push_back(make_line(dbf_pkg::OP_LUMA_NORMAL, 10, 11, 12, 13, 14, 15, 16, 17,
                                  40, 0, 4));
        // Luma skip on a negative limit
        lines.push_back(make_line(dbf_pkg::OP_LUMA_NORMAL, 60, 62, 64, 66, 74, 76, 78, 80,
                                  20, 10, -1));
        // Zero luma limit still moves p0/q0 through the side growth
        lines.push_back(make_line(dbf_pkg::OP_LUMA_NORMAL, 60, 62, 64, 66, 74, 76, 78, 80,
                                  20, 10, 0));
        lines.push_back(make_line(dbf_pkg::OP_LUMA_NORMAL, 40, 45, 50, 56, 70, 75, 79, 84,
                                  30, 12, 4));
        lines.push_back(make_line(dbf_pkg::OP_LUMA_NORMAL, 40, 45, 50, 56, 70, 75, 120, 84,
                                  30, 12, 4));
        // Saturate p0 high and low
        lines.push_back(make_line(dbf_pkg::OP_LUMA_NORMAL, 255, 255, 255, 250, 255, 1,
                                  255, 255, 255, 255, 26));
        lines.push_back(make_line(dbf_pkg::OP_LUMA_NORMAL, 0, 0, 0, 5, 0, 254, 0, 0,
                                  255, 255, 26));
        lines.push_back(make_line(dbf_pkg::OP_CHROMA_NORMAL, 255, 255, 255, 250, 255, 1,
                                  255, 255, 255, 255, 26));
        lines.push_back(make_line(dbf_pkg::OP_CHROMA_NORMAL, 0, 0, 0, 5, 0, 254, 0, 0,
                                  255, 255, 26));
        // Chroma skip on a limit of zero or less, and a limit of one that filters
        lines.push_back(make_line(dbf_pkg::OP_CHROMA_NORMAL, 60, 62, 64, 66, 74, 76, 78,
                                  80, 20, 10, 0));
        lines.push_back(make_line(dbf_pkg::OP_CHROMA_NORMAL, 60, 62, 64, 66, 74, 76, 78,
                                  80, 20, 10, -1));
        lines.push_back(make_line(dbf_pkg::OP_CHROMA_NORMAL, 60, 62, 64, 66, 74, 76, 78,
                                  80, 20, 10, 1));
        // Strong luma: both sides, one side, and a step too large for smoothing
        lines.push_back(make_line(dbf_pkg::OP_LUMA_STRONG, 90, 92, 94, 96, 100, 102, 104,
                                  106, 40, 10, 3));
        lines.push_back(make_line(dbf_pkg::OP_LUMA_STRONG, 90, 130, 94, 96, 100, 102, 104,
                                  106, 40, 10, 3));
        lines.push_back(make_line(dbf_pkg::OP_LUMA_STRONG, 90, 92, 94, 96, 100, 102, 30,
                                  106, 40, 10, 3));
        lines.push_back(make_line(dbf_pkg::OP_LUMA_STRONG, 100, 100, 100, 100, 180, 180,
                                  180, 180, 255, 255, 0));
        lines.push_back(make_line(dbf_pkg::OP_LUMA_STRONG, 0, 255, 255, 255, 255, 255,
                                  255, 255, 255, 255, -1));
        lines.push_back(make_line(dbf_pkg::OP_LUMA_STRONG, 255, 0, 0, 0, 0, 0, 0, 0,
                                  255, 255, 26));
        lines.push_back(make_line(dbf_pkg::OP_CHROMA_STRONG, 50, 52, 54, 57, 63, 60, 58,
                                  55, 20, 8, 26));
        lines.push_back(make_line(dbf_pkg::OP_CHROMA_STRONG, 50, 52, 54, 57, 63, 60, 58,
                                  55, 0, 8, 0));
        foreach (lines[i]) send_line(lines[i]);
        wait_results();
    endtask

    // Run back to back with no idling on either side
    task automatic test_stream();
        stall_en = 1'b0;
        repeat (CHUNK_LINES) send_line(random_line());
        wait_results();
    endtask

    task automatic test_random();
        for (int chunk = 0; chunk < RANDOM_LINES / CHUNK_LINES; chunk++) begin
            stall_en = ($urandom_range(0, 3) != 0);
            repeat (CHUNK_LINES) send_line(random_line());
            if (chunk % 3 == 2) wait_results();
        end
        wait_results();
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // Drive the result ready with random stalls
    initial begin
        int r;
        res_if.ready = 1'b0;
        forever begin
            @(negedge clk);
            r = $urandom_range(0, 99);
            if (!stall_en || r < 70) begin
                res_if.ready = 1'b1;
            end else begin
                res_if.ready = 1'b0;
                if (r < 95) repeat ($urandom_range(1, 3) - 1) @(negedge clk);
                else repeat ($urandom_range(8, 30) - 1) @(negedge clk);
            end
        end
    end

    // Compare each returned result with the oldest expected one
    always @(posedge clk) begin
        if (rst_n === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
            if (exp_lines.size() == 0) begin
                $display("%0t: unexpected result, expected none actual p0=%0d q0=%0d",
                         $time, res_if.p0_out, res_if.q0_out);
                mismatch_count++;
            end else begin
                want_res = exp_lines.pop_front();
                check_field("p2_out", int'(want_res.p2), int'(res_if.p2_out));
                check_field("p1_out", int'(want_res.p1), int'(res_if.p1_out));
                check_field("p0_out", int'(want_res.p0), int'(res_if.p0_out));
                check_field("q0_out", int'(want_res.q0), int'(res_if.q0_out));
                check_field("q1_out", int'(want_res.q1), int'(res_if.q1_out));
                check_field("q2_out", int'(want_res.q2), int'(res_if.q2_out));
                check_field("filtered", int'(want_res.filtered), int'(res_if.filtered));
            end
        end
    end

    // Reset once, run the tests in turn, report
    initial begin
        mismatch_count     = 0;
        stall_en           = 1'b0;
        rst_n              = 1'b0;
        line_if.valid      = 1'b0;
        line_if.op         = dbf_pkg::OP_LUMA_NORMAL;
        line_if.p3_in      = '0;
        line_if.p2_in      = '0;
        line_if.p1_in      = '0;
        line_if.p0_in      = '0;
        line_if.q0_in      = '0;
        line_if.q1_in      = '0;
        line_if.q2_in      = '0;
        line_if.q3_in      = '0;
        line_if.edge_alpha = '0;
        line_if.edge_beta  = '0;
        line_if.clip_base  = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_stream();
        test_random();
        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/dbf_pkg.sv
hdl/dbf_if.sv
hdl/dbf_grad.sv
hdl/dbf_clip.sv
hdl/dbf_apply.sv
hdl/deblocking_edge_filter.sv
verif/tb_deblocking_edge_filter.sv
